### design/ngze_pkg.sv
// Package for the NMEA GGA/ZDA field extractor.
// Holds character codes, field identifiers, hemisphere codes and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ngze_pkg;

    // Widths fixed by the result fields.
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned FIELD_ID_W     = 4;
    localparam int unsigned FIELD_VALUE_W  = 31;
    localparam int unsigned HEMI_W         = 3;
    localparam int unsigned PREFIX_POS_W   = 3;
    localparam int unsigned VALUE_BITS_DEF = 31;

    // Prefix length including the leading dollar and the trailing comma.
    localparam logic [PREFIX_POS_W-1:0] PREFIX_LEN = 3'd7;

    // Characters of interest.
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_D      = 8'h44;
    localparam logic [BYTE_W-1:0] CHAR_E      = 8'h45;
    localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CHAR_S      = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_W      = 8'h57;
    localparam logic [BYTE_W-1:0] CHAR_Z      = 8'h5A;

    // Sentence kinds.
    localparam logic KIND_GGA = 1'b0;
    localparam logic KIND_ZDA = 1'b1;

    // Candidate mask bits.
    localparam logic [1:0] CAND_BOTH = 2'b11;
    localparam logic [1:0] CAND_GGA  = 2'b01;
    localparam logic [1:0] CAND_ZDA  = 2'b10;
    localparam logic [1:0] CAND_NONE = 2'b00;

    // Field counter values with special meaning.
    localparam logic [FIELD_ID_W-1:0] GGA_TIME_SLOT   = 4'd0;
    localparam logic [FIELD_ID_W-1:0] GGA_LAT_HEMI    = 4'd2;
    localparam logic [FIELD_ID_W-1:0] GGA_LON_HEMI    = 4'd4;
    localparam logic [FIELD_ID_W-1:0] GGA_LAST_SLOT   = 4'd8;
    localparam logic [FIELD_ID_W-1:0] ZDA_LAST_SLOT   = 4'd3;
    localparam logic [FIELD_ID_W-1:0] ZDA_ID_BASE     = 4'd8;

    // Hemisphere codes.
    localparam logic [HEMI_W-1:0] HEMI_UNKNOWN = 3'd0;
    localparam logic [HEMI_W-1:0] HEMI_NORTH   = 3'd1;
    localparam logic [HEMI_W-1:0] HEMI_SOUTH   = 3'd2;
    localparam logic [HEMI_W-1:0] HEMI_EAST    = 3'd3;
    localparam logic [HEMI_W-1:0] HEMI_WEST    = 3'd4;

    // One result beat.
    typedef struct packed {
        logic                     valid;
        logic                     kind;
        logic [FIELD_ID_W-1:0]    field_id;
        logic [FIELD_VALUE_W-1:0] value;
        logic                     last;
    } ngze_result_t;

    // Expected prefix character at a position for one sentence kind.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic kind,
                                                      input logic [PREFIX_POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = CHAR_DOLLAR;
            3'd1:    ch = CHAR_G;
            3'd2:    ch = CHAR_N;
            3'd3:    ch = (kind == KIND_ZDA) ? CHAR_Z : CHAR_G;
            3'd4:    ch = (kind == KIND_ZDA) ? CHAR_D : CHAR_G;
            3'd5:    ch = CHAR_A;
            3'd6:    ch = CHAR_COMMA;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Hemisphere code from a character.
    function automatic logic [HEMI_W-1:0] hemi_of(input logic [BYTE_W-1:0] ch);
        logic [HEMI_W-1:0] code;
        case (ch)
            CHAR_N:  code = HEMI_NORTH;
            CHAR_S:  code = HEMI_SOUTH;
            CHAR_E:  code = HEMI_EAST;
            CHAR_W:  code = HEMI_WEST;
            default: code = HEMI_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### design/ngze_parser.sv
// Per-byte sentence parser: prefix matching, field splitting and digit accumulation.
// Depends on ngze_pkg. Produces at most one result per processed byte.
`timescale 1ns / 1ps
`default_nettype none

module ngze_parser #(
    parameter int unsigned VALUE_BITS = ngze_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [ngze_pkg::BYTE_W-1:0]    rx_byte,
    output ngze_pkg::ngze_result_t              result
);

    localparam int unsigned MUL_W = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    logic [ngze_pkg::PREFIX_POS_W-1:0] prefix_pos_reg, prefix_pos_next;
    logic [1:0]                        cand_reg, cand_next;
    logic                              in_sentence_reg, in_sentence_next;
    logic                              kind_reg, kind_next;
    logic [ngze_pkg::FIELD_ID_W-1:0]   field_cnt_reg, field_cnt_next;
    logic [VALUE_BITS-1:0]             acc_reg, acc_next;
    logic [ngze_pkg::HEMI_W-1:0]       hemi_reg, hemi_next;
    logic                              first_char_reg, first_char_next;

    logic                              hemi_slot;
    logic                              is_digit;
    logic [1:0]                        cand_match;
    logic [ngze_pkg::PREFIX_POS_W-1:0] pos_inc;
    logic [MUL_W-1:0]                  acc_times_ten;
    logic [MUL_W-1:0]                  acc_sum;
    logic [3:0]                        digit_raw;
    logic [VALUE_BITS+ngze_pkg::FIELD_VALUE_W-1:0] acc_wide;
    logic                              last_slot;

    assign hemi_slot = (kind_reg == ngze_pkg::KIND_GGA)
                       && ((field_cnt_reg == ngze_pkg::GGA_LAT_HEMI)
                           || (field_cnt_reg == ngze_pkg::GGA_LON_HEMI));
    assign is_digit  = (rx_byte >= ngze_pkg::CHAR_ZERO) && (rx_byte <= ngze_pkg::CHAR_NINE);
    assign digit_raw = 4'(rx_byte - ngze_pkg::CHAR_ZERO);

    // Multiply by ten as two shifts, then add the digit; saturate on overflow.
    assign acc_times_ten = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1);
    assign acc_sum       = acc_times_ten + MUL_W'(digit_raw);

    // Candidate narrowing for the current prefix position.
    always_comb begin
        cand_match = cand_reg;
        if (ngze_pkg::prefix_char(ngze_pkg::KIND_GGA, prefix_pos_reg) != rx_byte) begin
            cand_match = cand_match & ngze_pkg::CAND_ZDA;
        end
        if (ngze_pkg::prefix_char(ngze_pkg::KIND_ZDA, prefix_pos_reg) != rx_byte) begin
            cand_match = cand_match & ngze_pkg::CAND_GGA;
        end
    end
    assign pos_inc = prefix_pos_reg + 3'd1;

    assign last_slot = (kind_reg == ngze_pkg::KIND_GGA)
                       ? (field_cnt_reg == ngze_pkg::GGA_LAST_SLOT)
                       : (field_cnt_reg == ngze_pkg::ZDA_LAST_SLOT);
    assign acc_wide  = {{ngze_pkg::FIELD_VALUE_W{1'b0}}, acc_reg};

    // Next-state and result for one byte.
    always_comb begin
        prefix_pos_next  = prefix_pos_reg;
        cand_next        = cand_reg;
        in_sentence_next = in_sentence_reg;
        kind_next        = kind_reg;
        field_cnt_next   = field_cnt_reg;
        acc_next         = acc_reg;
        hemi_next        = hemi_reg;
        first_char_next  = first_char_reg;
        result           = '0;

        if (rx_byte == ngze_pkg::CHAR_DOLLAR) begin
            in_sentence_next = 1'b0;
            prefix_pos_next  = 3'd1;
            cand_next        = ngze_pkg::CAND_BOTH;
        end else if (!in_sentence_reg) begin
            if ((prefix_pos_reg == 3'd0) || (prefix_pos_reg >= ngze_pkg::PREFIX_LEN)
                || (cand_match == ngze_pkg::CAND_NONE)) begin
                prefix_pos_next = 3'd0;
                cand_next       = ngze_pkg::CAND_BOTH;
            end else if (pos_inc == ngze_pkg::PREFIX_LEN) begin
                in_sentence_next = 1'b1;
                kind_next        = cand_match[1] ? ngze_pkg::KIND_ZDA : ngze_pkg::KIND_GGA;
                field_cnt_next   = '0;
                acc_next         = '0;
                hemi_next        = ngze_pkg::HEMI_UNKNOWN;
                first_char_next  = 1'b1;
                prefix_pos_next  = 3'd0;
                cand_next        = ngze_pkg::CAND_BOTH;
            end else begin
                prefix_pos_next = pos_inc;
                cand_next       = cand_match;
            end
        end else if (rx_byte != ngze_pkg::CHAR_COMMA) begin
            // Inside a field: hemisphere letter or decimal digit.
            if (hemi_slot) begin
                if (first_char_reg) begin
                    hemi_next = ngze_pkg::hemi_of(rx_byte);
                end
            end else if (is_digit) begin
                if (acc_sum > MUL_W'(VALUE_MAX)) begin
                    acc_next = VALUE_MAX;
                end else begin
                    acc_next = acc_sum[VALUE_BITS-1:0];
                end
            end
            first_char_next = 1'b0;
        end else begin
            // Comma closes the field; the GGA time field gives no result.
            result.kind  = kind_reg;
            result.last  = last_slot;
            result.value = hemi_slot ? ngze_pkg::FIELD_VALUE_W'(hemi_reg)
                                     : acc_wide[ngze_pkg::FIELD_VALUE_W-1:0];
            if (kind_reg == ngze_pkg::KIND_GGA) begin
                result.valid    = (field_cnt_reg != ngze_pkg::GGA_TIME_SLOT);
                result.field_id = field_cnt_reg - 4'd1;
            end else begin
                result.valid    = 1'b1;
                result.field_id = ngze_pkg::ZDA_ID_BASE + field_cnt_reg;
            end
            if (last_slot) begin
                in_sentence_next = 1'b0;
                field_cnt_next   = '0;
            end else begin
                field_cnt_next   = field_cnt_reg + 4'd1;
            end
            acc_next        = '0;
            hemi_next       = ngze_pkg::HEMI_UNKNOWN;
            first_char_next = 1'b1;
        end

        if (!step) begin
            result.valid = 1'b0;
        end
    end

    // State registers, updated once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_pos_reg  <= '0;
            cand_reg        <= ngze_pkg::CAND_BOTH;
            in_sentence_reg <= 1'b0;
            kind_reg        <= ngze_pkg::KIND_GGA;
            field_cnt_reg   <= '0;
            acc_reg         <= '0;
            hemi_reg        <= ngze_pkg::HEMI_UNKNOWN;
            first_char_reg  <= 1'b1;
        end else if (step) begin
            prefix_pos_reg  <= prefix_pos_next;
            cand_reg        <= cand_next;
            in_sentence_reg <= in_sentence_next;
            kind_reg        <= kind_next;
            field_cnt_reg   <= field_cnt_next;
            acc_reg         <= acc_next;
            hemi_reg        <= hemi_next;
            first_char_reg  <= first_char_next;
        end
    end

endmodule

`default_nettype wire

### design/nmea_gga_zda_field_extractor.sv
// Flow: an accepted byte is registered in the input register; its field result, if
// any, enters the output register as the byte is processed and m_valid goes high.
// Throughput: one byte per cycle while the output register is free, which it is
// once m_ready takes the waiting beat; the parser steps once per processed byte.
// Reset: synchronous active-low aresetn clears the parser to idle and empties both
// the input and the output register.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gga_zda_field_extractor #(
    parameter int unsigned VALUE_BITS = ngze_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [ngze_pkg::BYTE_W-1:0]           s_rx_byte,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_sentence_kind,
    output logic [ngze_pkg::FIELD_ID_W-1:0]            m_field_id,
    output logic [ngze_pkg::FIELD_VALUE_W-1:0]         m_field_value,
    output logic                                       m_last_field
);

    logic                          in_valid_reg;
    logic [ngze_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          advance;
    logic                          out_free;
    ngze_pkg::ngze_result_t        result;
    ngze_pkg::ngze_result_t        out_reg;

    // The held byte is processed when the output register can take its beat.
    assign out_free = !out_reg.valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    ngze_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // Output register holding one result beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (out_free) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_reg.valid;
    assign m_sentence_kind = out_reg.kind;
    assign m_field_id      = out_reg.field_id;
    assign m_field_value   = out_reg.value;
    assign m_last_field    = out_reg.last;

endmodule

`default_nettype wire
